// ===== src/po_pkg.sv =====
// Shared types and constants for the permutation order block.
package po_pkg;

  // Width of one permutation element and of the length register.
  localparam int unsigned ElemW = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_wr;
    logic clear;
    logic load;
    logic round_go;
    logic emit_load;
    logic emit_round;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic bad_now;
    logic id_now;
    logic round_done;
    logic round_ident;
    logic rc_sat;
  } sts_t;

endpackage

// ===== src/permutation_order_core.sv =====
// A permutation of n elements takes n element transfers, one per cycle while not busy.
// An invalid or identity permutation gives its result in the cycle after the last element.
// Otherwise the block is busy for (order - 1) composition rounds, and the result follows in
// the cycle after the last round ends. The result strobe is high for exactly one cycle; the
// receiver cannot stall it. Reset clears the load state and sets the length to 16, or to
// MAX_ELEMS if that is smaller; the stores need no clearing.
module permutation_order_core #(
  parameter int unsigned MAX_ELEMS  = 16,
  parameter int unsigned ORDER_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [po_pkg::ElemW-1:0] element_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [po_pkg::ElemW-1:0] cfg_data_i,
  output logic                     result_valid_o,
  output logic [ORDER_BITS-1:0]    order_o,
  output logic                     error_o
);

  po_pkg::cmd_t cmd;
  po_pkg::sts_t sts;

  // The length register takes a transfer in any cycle.
  assign cfg_ready_o = 1'b1;

  po_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  po_dp #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ORDER_BITS (ORDER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_data_i     (cfg_data_i),
    .element_i      (element_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .order_o        (order_o),
    .error_o        (error_o)
  );

endmodule

// ===== src/po_ctrl.sv =====
// Controller state machine for the permutation order block.
module po_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         cfg_valid_i,
  input  po_pkg::sts_t sts_i,
  output po_pkg::cmd_t cmd_o,
  output logic         busy
);

  localparam logic StLoad = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_d, state_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (cfg_valid_i) begin
      // A new length restarts the load and stops any round in progress.
      cmd_o.cfg_wr = 1'b1;
      cmd_o.clear  = 1'b1;
      state_d      = StLoad;
    end else begin
      case (state_q)
        StLoad: begin
          if (start) begin
            cmd_o.load = 1'b1;
            if (sts_i.last) begin
              if (sts_i.bad_now || sts_i.id_now) begin
                cmd_o.emit_load = 1'b1;
                cmd_o.clear     = 1'b1;
              end else begin
                cmd_o.round_go = 1'b1;
                state_d        = StRun;
              end
            end
          end
        end
        StRun: begin
          if (sts_i.round_done) begin
            if (sts_i.round_ident || sts_i.rc_sat) begin
              cmd_o.emit_round = 1'b1;
              cmd_o.clear      = 1'b1;
              state_d          = StLoad;
            end else begin
              cmd_o.round_go = 1'b1;
            end
          end
        end
        default: begin
          state_d = StLoad;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q == StRun);

  // No element transfer may be taken while rounds are running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !cmd_o.load)
    else $error("element load while busy");

  // A round is only started from a load or from the end of a round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.round_go |-> (cmd_o.load || sts_i.round_done))
    else $error("round started without cause");

  // A result after rounds always comes from the running state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_round |-> (state_q == StRun))
    else $error("round result outside running state");

endmodule

// ===== src/po_dp.sv =====
// Datapath for the permutation order block: stores, checks and round engine.
module po_dp #(
  parameter int unsigned MAX_ELEMS  = 16,
  parameter int unsigned ORDER_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  po_pkg::cmd_t             cmd_i,
  input  logic [po_pkg::ElemW-1:0] cfg_data_i,
  input  logic [po_pkg::ElemW-1:0] element_i,
  output po_pkg::sts_t             sts_o,
  output logic                     result_valid_o,
  output logic [ORDER_BITS-1:0]    order_o,
  output logic                     error_o
);

  localparam int unsigned EW    = po_pkg::ElemW;
  localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
  localparam int unsigned LEN_RST = (MAX_ELEMS < 16) ? MAX_ELEMS : 16;

  // Length register and load checking.
  logic [EW-1:0]        len_q;
  logic [EW-1:0]        len_d;
  logic [EW-1:0]        load_q;
  logic [MAX_ELEMS-1:0] seen_q;
  logic                 bad_q;
  logic                 id_q;

  logic [EW-1:0]    load_inc;
  logic [EW-1:0]    elem_m1;
  logic [IDX_W-1:0] seen_idx;
  logic [IDX_W-1:0] ld_idx;
  logic             elem_bad;

  always_comb begin
    if (cfg_data_i == '0) begin
      len_d = EW'(1);
    end else if ({1'b0, cfg_data_i} > (EW + 1)'(MAX_ELEMS)) begin
      len_d = EW'(MAX_ELEMS);
    end else begin
      len_d = cfg_data_i;
    end
  end

  assign load_inc = load_q + EW'(1);
  assign elem_m1  = element_i - EW'(1);
  assign seen_idx = elem_m1[IDX_W-1:0];
  assign ld_idx   = load_q[IDX_W-1:0];
  assign elem_bad = (element_i == '0) || (element_i > len_q) || seen_q[seen_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= EW'(LEN_RST);
      load_q <= '0;
      seen_q <= '0;
      bad_q  <= 1'b0;
      id_q   <= 1'b1;
    end else begin
      if (cmd_i.cfg_wr) begin
        len_q <= len_d;
      end
      if (cmd_i.clear) begin
        load_q <= '0;
        seen_q <= '0;
        bad_q  <= 1'b0;
        id_q   <= 1'b1;
      end else if (cmd_i.load) begin
        load_q <= load_inc;
        if (elem_bad) begin
          bad_q <= 1'b1;
        end else begin
          seen_q[seen_idx] <= 1'b1;
        end
        if (element_i != load_inc) begin
          id_q <= 1'b0;
        end
      end
    end
  end

  // Round engine: issue, read work bank, write other bank.
  logic             run_q;
  logic [EW-1:0]    iss_q;
  logic             v1_q, v2_q;
  logic [EW-1:0]    a1_q, a2_q;
  logic             cur_q;
  logic             mism_q;
  logic [ORDER_BITS-1:0] rc_q;

  logic [EW-1:0]    perm_rd_q;
  logic [EW-1:0]    rd0_q, rd1_q;
  logic [EW-1:0]    wrd;
  logic [EW-1:0]    src_m1;
  logic [EW-1:0]    len_m1;
  logic [ORDER_BITS-1:0] rc_inc;
  logic             wr_mism;

  logic [EW-1:0] perm_mem_q [MAX_ELEMS];
  logic [EW-1:0] bank0_q    [MAX_ELEMS];
  logic [EW-1:0] bank1_q    [MAX_ELEMS];

  assign len_m1  = len_q - EW'(1);
  assign src_m1  = perm_rd_q - EW'(1);
  assign wrd     = cur_q ? rd1_q : rd0_q;
  assign wr_mism = (wrd != (a2_q + EW'(1)));
  assign rc_inc  = rc_q + ORDER_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      iss_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cur_q  <= 1'b0;
      mism_q <= 1'b0;
      rc_q   <= ORDER_BITS'(1);
    end else if (cmd_i.clear) begin
      run_q  <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cur_q  <= 1'b0;
      mism_q <= 1'b0;
      rc_q   <= ORDER_BITS'(1);
    end else begin
      v1_q <= run_q;
      v2_q <= v1_q;
      if (cmd_i.round_go) begin
        run_q  <= 1'b1;
        iss_q  <= '0;
      end else if (run_q) begin
        iss_q <= iss_q + EW'(1);
        if (iss_q == len_m1) begin
          run_q <= 1'b0;
        end
      end
      // A new round starts with a clean mismatch flag, even when the last
      // write of the previous round mismatched in the same cycle.
      if (cmd_i.round_go) begin
        mism_q <= 1'b0;
      end else if (v2_q && wr_mism) begin
        mism_q <= 1'b1;
      end
      if (sts_o.round_done) begin
        cur_q <= ~cur_q;
        rc_q  <= rc_inc;
      end
    end
  end

  // Stage addresses carry no reset; they are qualified by the valid bits.
  always_ff @(posedge clk_i) begin
    a1_q <= iss_q;
    a2_q <= a1_q;
  end

  // Loaded permutation; also copied into bank 0 as the first working copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      perm_mem_q[ld_idx] <= element_i;
    end
    perm_rd_q <= perm_mem_q[iss_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bank0_q[ld_idx] <= element_i;
    end else if (v2_q && cur_q) begin
      bank0_q[a2_q[IDX_W-1:0]] <= wrd;
    end
    rd0_q <= bank0_q[src_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && !cur_q) begin
      bank1_q[a2_q[IDX_W-1:0]] <= wrd;
    end
    rd1_q <= bank1_q[src_m1[IDX_W-1:0]];
  end

  always_comb begin
    sts_o             = '0;
    sts_o.last        = (load_inc >= len_q);
    sts_o.bad_now     = bad_q || elem_bad;
    sts_o.id_now      = id_q && (element_i == load_inc);
    sts_o.round_done  = v2_q && (a2_q == len_m1);
    sts_o.round_ident = !(mism_q || wr_mism);
    sts_o.rc_sat      = &rc_inc;
  end

  // Result register.
  logic                  res_valid_q;
  logic [ORDER_BITS-1:0] order_q;
  logic                  error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_load || cmd_i.emit_round;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      error_q <= sts_o.bad_now;
      order_q <= sts_o.bad_now ? '0 : ORDER_BITS'(1);
    end else if (cmd_i.emit_round) begin
      error_q <= 1'b0;
      order_q <= rc_inc;
    end
  end

  assign result_valid_o = res_valid_q;
  assign order_o        = order_q;
  assign error_o        = error_q;

  // The last element of a round drains only after issue has stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sts_o.round_done |-> !run_q)
    else $error("round finished while still issuing");

  // A flagged result carries order zero, a good one a nonzero order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (error_o == (order_o == '0)))
    else $error("order and error disagree");

  // Round results are only produced once the last stage has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_round |-> sts_o.round_done)
    else $error("round result without finished round");

endmodule
